/* hdl/bads_pkg.sv */
// ----------------------------------------------------------------------------
// bads_pkg: shared types and constants of the box average density shader
// Channel payloads, window tap bundle, register indexes and the fixed-point
// reciprocals that turn the box sum into a Q.10 level.
// ----------------------------------------------------------------------------
package bads_pkg;

   // grid limits and field widths
   localparam int MAX_WIDTH      = 128;
   localparam int MAX_HEIGHT     = 128;
   localparam int COUNT_BITS     = 8;
   localparam int DIM_BITS       = 8;
   localparam int INS_BITS       = $clog2(MAX_WIDTH);
   localparam int CELLS_BITS     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int HS_BITS        = $clog2(3 * ((2 ** COUNT_BITS) - 1) + 1);
   localparam int SUM_BITS       = $clog2(9 * ((2 ** COUNT_BITS) - 1) + 1);
   localparam int LEVEL_BITS     = 16;

   // reciprocals: floor(v * 1024 / D) == (v * RECIP) >> RECIP_SHIFT over the value range
   localparam int RECIP_SHIFT    = 18;
   localparam int RECIP_BITS     = 25;
   localparam logic [RECIP_BITS-1:0] RECIP_BOX  = 25'd2982617;   // 1024 / 90
   localparam logic [RECIP_BITS-1:0] RECIP_CELL = 25'd26843546;  // 1024 / 10
   localparam int PROD_BITS      = SUM_BITS + RECIP_BITS;

   // output queue
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_BITS     = $clog2(QUEUE_DEPTH);

   // register port
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [DIM_BITS-1:0] GRID_WIDTH_RESET  = 8'd64;
   localparam logic [DIM_BITS-1:0] GRID_HEIGHT_RESET = 8'd64;

   typedef struct packed {
      logic [COUNT_BITS-1:0] cell_count;
      logic                  flush;
   } req_type;

   typedef struct packed {
      logic signed [LEVEL_BITS-1:0] blue_level;
      logic                         opaque;
      logic                         frame_end;
   } rsp_type;

   // one chain cell: row sum one line back, center count, row sum two lines back
   typedef struct packed {
      logic [HS_BITS-1:0]    hs_a;
      logic [COUNT_BITS-1:0] center;
      logic [HS_BITS-1:0]    hs_b;
   } tap_type;

   // result pending after a push
   typedef struct packed {
      logic valid;
      logic in_box;
      logic frame_end;
   } emit_type;

   // selected value on its way to scaling
   typedef struct packed {
      logic                valid;
      logic                in_box;
      logic                frame_end;
      logic [SUM_BITS-1:0] value;
   } stage_type;

endpackage

/* hdl/bads_cell.sv */
// ----------------------------------------------------------------------------
// bads_cell: one stage of the line delay chain
// Loads either its upstream neighbor or the broadcast insert value on a push.
// ----------------------------------------------------------------------------
module bads_cell (
   input  logic              clock,
   input  logic              shift,
   input  logic              insert,
   input  bads_pkg::tap_type ins_value,
   input  bads_pkg::tap_type prev_value,
   output bads_pkg::tap_type value
);
   import bads_pkg::*;

   tap_type value_ff;
   tap_type value_in;

   // insertion point picks the fresh value, others take the neighbor
   always_comb begin
      value_in = insert ? ins_value : prev_value;
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

/* hdl/bads_chain.sv */
// ----------------------------------------------------------------------------
// bads_chain: variable-length line delay built from a row of cells
// Values enter at cell MAX_WIDTH-w and leave at the last cell, so the
// output lags the insert value by exactly w pushes.
// ----------------------------------------------------------------------------
module bads_chain (
   input  logic                          clock,
   input  logic                          shift,
   input  logic [bads_pkg::INS_BITS-1:0] ins_point,
   input  bads_pkg::tap_type             ins_value,
   output bads_pkg::tap_type             out_value
);
   import bads_pkg::*;

   tap_type link [MAX_WIDTH];

   genvar k;
   generate
      for (k = 0; k < MAX_WIDTH; k++) begin : g_cell
         tap_type prev_value;
         if (k == 0) begin : g_head
            assign prev_value = '0;
         end else begin : g_body
            assign prev_value = link[k-1];
         end
         bads_cell u_cell (
            .clock      (clock),
            .shift      (shift),
            .insert     (ins_point == INS_BITS'(k)),
            .ins_value  (ins_value),
            .prev_value (prev_value),
            .value      (link[k])
         );
      end
   endgenerate

   assign out_value = link[MAX_WIDTH-1];

endmodule

/* hdl/bads_scale.sv */
// ----------------------------------------------------------------------------
// bads_scale: average and level formatting stage
// Registers the selected value, multiplies by the box or cell reciprocal and
// forms 1024 minus the truncated average in Q.10.
// ----------------------------------------------------------------------------
module bads_scale (
   input  logic                clock,
   input  logic                reset,
   input  bads_pkg::stage_type stage_in,
   output logic                item_valid,
   output bads_pkg::rsp_type   item
);
   import bads_pkg::*;

   localparam logic signed [LEVEL_BITS-1:0] LEVEL_ONE = 16'sd1024;

   logic                valid_ff;
   logic                inside_ff;
   logic                frame_end_ff;
   logic [SUM_BITS-1:0] value_ff;

   logic [RECIP_BITS-1:0] recip;
   logic [PROD_BITS-1:0]  product;
   logic [LEVEL_BITS-1:0] average;

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      inside_ff    <= stage_in.in_box;
      frame_end_ff <= stage_in.frame_end;
      value_ff     <= stage_in.value;
   end

   // reciprocal multiply, truncated average
   always_comb begin
      recip   = inside_ff ? RECIP_BOX : RECIP_CELL;
      product = PROD_BITS'(value_ff) * PROD_BITS'(recip);
      average = product[RECIP_SHIFT +: LEVEL_BITS];
   end

   always_comb begin
      item.blue_level = LEVEL_ONE - $signed(average);
      item.opaque     = (value_ff != '0);
      item.frame_end  = frame_end_ff;
   end

   assign item_valid = valid_ff;

endmodule

/* hdl/bads_queue.sv */
// ----------------------------------------------------------------------------
// bads_queue: small result queue in front of the response channel
// Decouples the fixed-latency datapath from response stalls.
// ----------------------------------------------------------------------------
module bads_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   input  bads_pkg::rsp_type wr_item,
   input  logic              rd_ready,
   output logic              rd_valid,
   output bads_pkg::rsp_type rd_item
);
   import bads_pkg::*;

   rsp_type               store_ff [QUEUE_DEPTH];
   logic [QUEUE_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_BITS-1:0] wr_ptr_in;
   logic [QUEUE_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_BITS-1:0] rd_ptr_in;
   logic [QUEUE_BITS:0]   count_ff;
   logic [QUEUE_BITS:0]   count_in;
   logic                  rd_xfer;

   // pointer and fill bookkeeping
   always_comb begin
      rd_xfer   = rd_valid & rd_ready;
      wr_ptr_in = wr_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd_xfer ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_BITS+1)'(wr_valid) - (QUEUE_BITS+1)'(rd_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (wr_valid) begin
         store_ff[wr_ptr_ff] <= wr_item;
      end
   end

   assign rd_valid = (count_ff != '0);
   assign rd_item  = store_ff[rd_ptr_ff];

endmodule

/* hdl/box_average_density_shader_unit.sv */
// ----------------------------------------------------------------------------
// box_average_density_shader_unit: 3x3 box average over a raster cell stream
// Cells in raster order give a blue level and opaque flag each, lagging by
// w+1 cells; flush items after the frame push out the pending results.
//
//   channel | ports                        | moves
//   --------+------------------------------+-------------------------------
//   req     | req_valid/req_ready/payload  | cell count or flush, per transfer
//   rsp     | rsp_valid/rsp_ready/payload  | blue level, opaque, frame end
//   csr     | csr_wr_en/csr_index/wdata    | grid width, grid height
//
// One item per clock while req_ready is high. A result passes the push,
// tap select and multiply into the 4-entry result queue, then it is offered.
// req_ready drops while 4 results are outstanding; a stalled rsp fills the
// queue and then holds req. Synchronous reset, no clearing pass: the line
// chain holds no valid data until the frame refills it.
// ----------------------------------------------------------------------------
module box_average_density_shader_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bads_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bads_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_wr_en,
   input  logic [bads_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bads_pkg::DIM_BITS-1:0]       csr_wdata
);
   import bads_pkg::*;

   // configuration
   logic [DIM_BITS-1:0]   grid_width_ff;
   logic [DIM_BITS-1:0]   grid_height_ff;
   logic [DIM_BITS-1:0]   w_eff;
   logic [DIM_BITS-1:0]   h_eff;
   logic [CELLS_BITS-1:0] n_cells;
   logic [DIM_BITS-1:0]   ins_full;
   logic                  single_row;
   logic                  csr_hit;

   // frame counters
   logic [CELLS_BITS-1:0] cr_ff;
   logic [CELLS_BITS-1:0] cr_in;
   logic [CELLS_BITS-1:0] rs_ff;
   logic [CELLS_BITS-1:0] rs_in;
   logic [CELLS_BITS-1:0] rs_inc;
   logic [CELLS_BITS:0]   rs_gap;

   // push and window
   logic                  accept;
   logic                  push;
   logic [COUNT_BITS-1:0] push_count;
   logic [COUNT_BITS-1:0] p0_ff;
   logic [COUNT_BITS-1:0] p1_ff;
   logic [COUNT_BITS-1:0] p2_ff;
   logic [HS_BITS-1:0]    h0;
   tap_type               tap_ins;
   tap_type               tap_out;

   // result tracking
   emit_type              emit_ff;
   emit_type              emit_in;
   stage_type             stage;
   logic                  item_valid;
   rsp_type               item;
   logic [QUEUE_BITS:0]   pend_ff;
   logic [QUEUE_BITS:0]   pend_in;
   logic                  rsp_xfer;
   logic [SUM_BITS-1:0]   box_sum;

   // clamped dimensions and chain insertion point
   always_comb begin
      if (grid_width_ff == '0) begin
         w_eff = DIM_BITS'(1);
      end else if (grid_width_ff > DIM_BITS'(MAX_WIDTH)) begin
         w_eff = DIM_BITS'(MAX_WIDTH);
      end else begin
         w_eff = grid_width_ff;
      end
      if (grid_height_ff == '0) begin
         h_eff = DIM_BITS'(1);
      end else if (grid_height_ff > DIM_BITS'(MAX_HEIGHT)) begin
         h_eff = DIM_BITS'(MAX_HEIGHT);
      end else begin
         h_eff = grid_height_ff;
      end
      n_cells    = CELLS_BITS'(16'(w_eff) * 16'(h_eff));
      ins_full   = DIM_BITS'(MAX_WIDTH) - w_eff;
      single_row = (h_eff == DIM_BITS'(1));
   end

   // register writes
   always_comb begin
      csr_hit = csr_wr_en && ((csr_index == CSR_GRID_WIDTH) || (csr_index == CSR_GRID_HEIGHT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_RESET;
         grid_height_ff <= GRID_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_wdata;
            CSR_GRID_HEIGHT: grid_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // frame control: push, counters and pending result
   always_comb begin
      accept     = req_valid & req_ready;
      rs_inc     = rs_ff + 1'b1;
      rs_gap     = (CELLS_BITS+1)'(rs_ff) + (CELLS_BITS+1)'(w_eff) + (CELLS_BITS+1)'(1);
      cr_in      = cr_ff;
      rs_in      = rs_ff;
      push       = 1'b0;
      push_count = '0;
      emit_in    = '0;
      priority if (csr_hit) begin
         cr_in = '0;
         rs_in = '0;
      end else if (accept) begin
         priority if (cr_ff >= n_cells) begin
            // all cells in: every item drains one pending result
            if (rs_ff < n_cells) begin
               push           = 1'b1;
               emit_in.valid  = 1'b1;
               emit_in.in_box = 1'b0;
               rs_in          = rs_inc;
               if (rs_inc >= n_cells) begin
                  emit_in.frame_end = 1'b1;
                  cr_in             = '0;
                  rs_in             = '0;
               end
            end else begin
               cr_in = '0;
               rs_in = '0;
            end
         end else if (!req_payload.flush) begin
            push       = 1'b1;
            push_count = req_payload.cell_count;
            cr_in      = cr_ff + 1'b1;
            if (rs_gap <= (CELLS_BITS+1)'(cr_ff)) begin
               emit_in.valid  = 1'b1;
               emit_in.in_box = ((CELLS_BITS+1)'(rs_ff) >=
                                 (CELLS_BITS+1)'(w_eff) + (CELLS_BITS+1)'(1));
               rs_in          = rs_inc;
               if (rs_inc >= n_cells) begin
                  emit_in.frame_end = 1'b1;
                  cr_in             = '0;
                  rs_in             = '0;
               end
            end
         end else begin
            // flush before the frame is complete: dropped
            cr_in = cr_ff;
         end
      end else begin
         // no transfer: counters hold
         cr_in = cr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cr_ff         <= '0;
         rs_ff         <= '0;
         emit_ff.valid <= 1'b0;
      end else begin
         cr_ff         <= cr_in;
         rs_ff         <= rs_in;
         emit_ff.valid <= emit_in.valid;
      end
      emit_ff.in_box    <= emit_in.in_box;
      emit_ff.frame_end <= emit_in.frame_end;
   end

   // newest three cells of the window row
   always_ff @(posedge clock) begin
      if (push) begin
         p0_ff <= push_count;
         p1_ff <= p0_ff;
         p2_ff <= p1_ff;
      end
   end

   // chain feed: row sum, center (one step earlier for a single-row grid), lagged row sum
   always_comb begin
      h0             = HS_BITS'(p0_ff) + HS_BITS'(p1_ff) + HS_BITS'(p2_ff);
      tap_ins.hs_a   = h0;
      tap_ins.center = single_row ? p0_ff : p1_ff;
      tap_ins.hs_b   = tap_out.hs_a;
   end

   bads_chain u_chain (
      .clock     (clock),
      .shift     (push),
      .ins_point (ins_full[INS_BITS-1:0]),
      .ins_value (tap_ins),
      .out_value (tap_out)
   );

   // tap select on the post-push window
   always_comb begin
      box_sum         = SUM_BITS'(h0) + SUM_BITS'(tap_out.hs_a) + SUM_BITS'(tap_out.hs_b);
      stage.valid     = emit_ff.valid;
      stage.in_box    = emit_ff.in_box;
      stage.frame_end = emit_ff.frame_end;
      stage.value     = emit_ff.in_box ? box_sum : SUM_BITS'(tap_out.center);
   end

   bads_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .stage_in   (stage),
      .item_valid (item_valid),
      .item       (item)
   );

   bads_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (item_valid),
      .wr_item  (item),
      .rd_ready (rsp_ready),
      .rd_valid (rsp_valid),
      .rd_item  (rsp_payload)
   );

   // outstanding results bound the queue fill
   always_comb begin
      rsp_xfer = rsp_valid & rsp_ready;
      pend_in  = pend_ff + (QUEUE_BITS+1)'(emit_in.valid) - (QUEUE_BITS+1)'(rsp_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   assign req_ready = (pend_ff < (QUEUE_BITS+1)'(QUEUE_DEPTH));

`ifndef NO_ASSERTIONS
   // outstanding results never exceed the queue
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= (QUEUE_BITS+1)'(QUEUE_DEPTH))
      else $error("outstanding results exceed queue depth");

   // results sent never run ahead of cells received
   a_rs_le_cr: assert property (@(posedge clock) disable iff (reset)
      rs_ff <= cr_ff)
      else $error("results sent ahead of cells received");

   // a queue write comes in the cycle after a pending result
   a_write_origin: assert property (@(posedge clock) disable iff (reset)
      item_valid |-> $past(emit_ff.valid))
      else $error("queue write without pending result");

   // an offered result is accounted as outstanding
   a_rsp_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pend_ff != '0))
      else $error("response offered with no outstanding result");
`endif

endmodule

/* bench/bads_shade_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bads_shade_checker: result predictor and comparator for the shader unit
// Watches the req, rsp and csr ports. Every req transfer runs through its own
// copy of the raster window and may queue one expected shade. Every rsp
// transfer is compared field by field against the oldest queued shade.
// ----------------------------------------------------------------------------
module bads_shade_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  bads_pkg::req_type                   req_payload,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  bads_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_wr_en,
   input  logic [bads_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bads_pkg::DIM_BITS-1:0]       csr_wdata,
   output int                                  mismatch_count,
   output int                                  shades_waiting
);
   import bads_pkg::*;

   localparam int LINE_DEPTH = 2 * MAX_WIDTH + 3;

   // window copy: ring of recent counts indexed by raster position
   logic [COUNT_BITS-1:0] count_ring [0:LINE_DEPTH-1];
   int unsigned           cells_in;
   int unsigned           shades_out;
   logic [DIM_BITS-1:0]   width_reg;
   logic [DIM_BITS-1:0]   height_reg;
   rsp_type               expected_shades [$];
   rsp_type               oldest;

   function automatic int unsigned grid_dim(logic [DIM_BITS-1:0] v, int unsigned hi);
      if (v == 0)
         return 1;
      if (v > hi)
         return hi;
      return v;
   endfunction

   function automatic int unsigned ring_at(int unsigned idx);
      return count_ring[idx % LINE_DEPTH];
   endfunction

   // shade for the next raster position still owed a result
   task automatic emit_shade(int unsigned w, int unsigned n);
      int unsigned r;
      int unsigned sum;
      int unsigned avg;
      logic [31:0] level;
      rsp_type     shade;
      begin
         r = shades_out;
         if ((r >= w + 1) && (r + w + 1 < n)) begin
            sum = ring_at(r - w - 1) + ring_at(r - w) + ring_at(r - w + 1)
                + ring_at(r - 1) + ring_at(r) + ring_at(r + 1)
                + ring_at(r + w - 1) + ring_at(r + w) + ring_at(r + w + 1);
            avg = (sum * 1024) / 90;
         end else begin
            sum = ring_at(r);
            avg = (sum * 1024) / 10;
         end
         level = 32'd1024 - avg;
         shade.blue_level = level[LEVEL_BITS-1:0];
         shade.opaque = (sum != 0);
         shades_out = r + 1;
         shade.frame_end = (shades_out >= n);
         // frame wrap
         if (shades_out >= n) begin
            shades_out = 0;
            cells_in = 0;
         end
         expected_shades.push_back(shade);
      end
   endtask

   task automatic take_cell(req_type item);
      int unsigned w;
      int unsigned n;
      begin
         w = grid_dim(width_reg, MAX_WIDTH);
         n = w * grid_dim(height_reg, MAX_HEIGHT);
         if (cells_in >= n) begin
            // frame complete: any item pushes one pending shade out
            if (shades_out < n)
               emit_shade(w, n);
            else begin
               cells_in = 0;
               shades_out = 0;
            end
         end else if (!item.flush) begin
            count_ring[cells_in % LINE_DEPTH] = item.cell_count;
            cells_in++;
            if (shades_out + w + 1 < cells_in)
               emit_shade(w, n);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINE_DEPTH; i++)
            count_ring[i] = '0;
         cells_in = 0;
         shades_out = 0;
         width_reg = GRID_WIDTH_RESET;
         height_reg = GRID_HEIGHT_RESET;
         expected_shades.delete();
         mismatch_count = 0;
      end else begin
         // result transfer: compare against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (expected_shades.size() == 0) begin
               $display("%0t: unexpected shade level=%0d opaque=%0d frame_end=%0d",
                        $time, rsp_payload.blue_level, rsp_payload.opaque,
                        rsp_payload.frame_end);
               mismatch_count++;
            end else begin
               oldest = expected_shades.pop_front();
               if (rsp_payload.blue_level !== oldest.blue_level) begin
                  $display("%0t: blue_level expected %0d actual %0d",
                           $time, oldest.blue_level, rsp_payload.blue_level);
                  mismatch_count++;
               end
               if (rsp_payload.opaque !== oldest.opaque) begin
                  $display("%0t: opaque expected %0d actual %0d",
                           $time, oldest.opaque, rsp_payload.opaque);
                  mismatch_count++;
               end
               if (rsp_payload.frame_end !== oldest.frame_end) begin
                  $display("%0t: frame_end expected %0d actual %0d",
                           $time, oldest.frame_end, rsp_payload.frame_end);
                  mismatch_count++;
               end
            end
         end
         // register writes restart the frame; unknown indexes are ignored
         if (csr_wr_en) begin
            if (csr_index == CSR_GRID_WIDTH) begin
               width_reg = csr_wdata;
               cells_in = 0;
               shades_out = 0;
            end else if (csr_index == CSR_GRID_HEIGHT) begin
               height_reg = csr_wdata;
               cells_in = 0;
               shades_out = 0;
            end
         end
         if (req_valid && req_ready)
            take_cell(req_payload);
      end
      shades_waiting = expected_shades.size();
   end

endmodule

/* bench/box_average_density_shader_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_average_density_shader_unit_test: stimulus and verdict for the shader
// Runs two directed frames, then random frames over a list of grid sizes
// with sender gaps, receiver stalls and a long rsp hold-off; the checker
// beside the unit predicts every shade and counts mismatches.
// ----------------------------------------------------------------------------
module box_average_density_shader_unit_test;
   import bads_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd2;
   localparam int NUM_GRIDS = 14;
   localparam int ITEM_TARGET = 1550;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   req_type                   req_payload;
   logic                      rsp_valid;
   logic                      rsp_ready;
   rsp_type                   rsp_payload;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [DIM_BITS-1:0]       csr_wdata;
   int                        mismatch_count;
   int                        shades_waiting;

   int                        req_idle_pct;
   int                        rsp_stall_pct;
   int                        rsp_hold_cycles;
   int                        items_sent;

   box_average_density_shader_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   bads_shade_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .shades_waiting (shades_waiting)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop
   initial begin
      #1000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // receiver: random stalls, plus a counted hold-off when requested
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_cycles--;
         end else
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   function automatic int unsigned grid_dim(logic [DIM_BITS-1:0] v);
      if (v == 0)
         return 1;
      if (v > MAX_WIDTH)
         return MAX_WIDTH;
      return v;
   endfunction

   function automatic logic [COUNT_BITS-1:0] random_count(bit sparse);
      if (sparse)
         return ($urandom_range(9) == 0) ? COUNT_BITS'($urandom_range(255)) : '0;
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return COUNT_BITS'($urandom_range(3));
         default: return COUNT_BITS'($urandom_range(255));
      endcase
   endfunction

   // one req transfer; entered and left at a falling edge, valid left high
   task automatic send_item(logic [COUNT_BITS-1:0] count, logic flush);
      begin
         while ($urandom_range(99) < req_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
         req_valid <= 1'b1;
         req_payload.cell_count <= count;
         req_payload.flush <= flush;
         do
            @(posedge clock);
         while (!req_ready);
         @(negedge clock);
      end
   endtask

   // drain: nothing offered, nothing owed, then let the pipeline settle
   task automatic wait_idle();
      begin
         req_valid <= 1'b0;
         while (shades_waiting != 0)
            @(negedge clock);
         repeat (8) @(negedge clock);
      end
   endtask

   task automatic load_grid(logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h, bit spare);
      begin
         csr_wr_en <= 1'b1;
         csr_index <= CSR_GRID_WIDTH;
         csr_wdata <= w;
         @(negedge clock);
         csr_index <= CSR_GRID_HEIGHT;
         csr_wdata <= h;
         @(negedge clock);
         if (spare) begin
            csr_index <= CSR_SPARE;
            csr_wdata <= DIM_BITS'($urandom_range(255));
            @(negedge clock);
         end
         csr_wr_en <= 1'b0;
         @(negedge clock);
      end
   endtask

   // one frame with random content; huge grids get a partial frame only
   task automatic send_frame(int unsigned w, int unsigned h);
      int unsigned n;
      int unsigned cells;
      int unsigned trail;
      bit          sparse;
      begin
         n = w * h;
         cells = (n > 400) ? (2 * w + 3 + $urandom_range(60)) : n;
         sparse = ($urandom_range(3) == 0);
         for (int unsigned i = 0; i < cells; i++) begin
            // stray flush inside the frame
            if ($urandom_range(99) < 3)
               send_item(random_count(1'b0), 1'b1);
            send_item(random_count(sparse), 1'b0);
            items_sent++;
         end
         if (cells == n) begin
            trail = w + 1;
            // short trailer: the next frame's first cells push the rest out
            if ($urandom_range(9) == 0)
               trail = $urandom_range(w + 1);
            for (int unsigned i = 0; i < trail; i++) begin
               send_item(COUNT_BITS'($urandom_range(255)), ($urandom_range(9) != 0));
               items_sent++;
            end
            if ($urandom_range(4) == 0)
               send_item(random_count(1'b0), 1'b1);
         end
      end
   endtask

   initial begin
      int unsigned         phase;
      int                  pick;
      logic [DIM_BITS-1:0] wr_w;
      logic [DIM_BITS-1:0] wr_h;
      int unsigned         w;
      int unsigned         h;
      int unsigned         frames;

      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_GRID_WIDTH;
      csr_wdata = '0;
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_cycles = 0;
      items_sent = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: 3x2 grid with stray flush, late cell in the trailer, extra flush
      load_grid(8'd3, 8'd2, 1'b0);
      send_item(8'd0, 1'b1);
      send_item(8'd255, 1'b0);
      send_item(8'd0, 1'b0);
      send_item(8'd170, 1'b0);
      send_item(8'd85, 1'b0);
      send_item(8'd9, 1'b1);
      send_item(8'd1, 1'b0);
      send_item(8'd128, 1'b0);
      send_item(8'd77, 1'b0);
      send_item(8'd0, 1'b1);
      send_item(8'd255, 1'b1);
      send_item(8'd0, 1'b1);
      send_item(8'd0, 1'b1);
      wait_idle();

      // directed: 3x3 grid of full counts gives the same level at the center as at the border
      load_grid(8'd3, 8'd3, 1'b0);
      repeat (9) send_item(8'd255, 1'b0);
      repeat (4) send_item(8'd0, 1'b1);
      wait_idle();

      // random frames over grid sizes and idling modes
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         pick = (phase < NUM_GRIDS) ? phase : $urandom_range(NUM_GRIDS - 1);
         case (pick)
            0:       begin wr_w = 8'd3;   wr_h = 8'd2;   end
            1:       begin wr_w = 8'd1;   wr_h = 8'd1;   end
            2:       begin wr_w = 8'd1;   wr_h = 8'd128; end
            3:       begin wr_w = 8'd2;   wr_h = 8'd5;   end
            4:       begin wr_w = 8'd5;   wr_h = 8'd4;   end
            5:       begin wr_w = 8'd7;   wr_h = 8'd3;   end
            6:       begin wr_w = 8'd128; wr_h = 8'd3;   end
            7:       begin wr_w = 8'd255; wr_h = 8'd0;   end
            8:       begin wr_w = 8'd0;   wr_h = 8'd255; end
            9:       begin wr_w = 8'd16;  wr_h = 8'd8;   end
            10:      begin wr_w = 8'd4;   wr_h = 8'd4;   end
            11:      begin wr_w = 8'd255; wr_h = 8'd255; end
            12:      begin wr_w = 8'd10;  wr_h = 8'd10;  end
            default: begin wr_w = 8'd128; wr_h = 8'd128; end
         endcase
         wait_idle();
         load_grid(wr_w, wr_h, (phase == 5));
         case (phase % 4)
            0:       begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin req_idle_pct = 66; rsp_stall_pct = 0;  end
            2:       begin req_idle_pct = 0;  rsp_stall_pct = 66; end
            default: begin req_idle_pct = 6;  rsp_stall_pct = 6;  end
         endcase
         // long rsp hold-off so the result queue fills and req backs up
         if (phase % 4 == 0)
            rsp_hold_cycles = 80;
         w = grid_dim(wr_w);
         h = grid_dim(wr_h);
         frames = (w * h <= 40) ? 3 : 1;
         repeat (frames) send_frame(w, h);
         phase++;
      end

      wait_idle();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && shades_waiting == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
